// File: rtl/fjq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS job queue package
// Shared sizes, event codes and record types for the job queue accounting unit.
// ----------------------------------------------------------------------------
package fjq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_ARRIVE = 1'b1;

  typedef enum logic [1:0] {
    EV_ENTERED  = 2'd0,
    EV_RUNNING  = 2'd1,
    EV_FINISHED = 2'd2,
    EV_REJECTED = 2'd3
  } evt_e_t;

  // One input request as held in the input register.
  typedef struct packed {
    logic        kind;
    logic [15:0] job_id;
    logic [15:0] service_ticks;
    logic [15:0] deadline_ticks;
  } itm_t;

  // One queued job.
  typedef struct packed {
    logic [15:0] job_id;
    logic [31:0] arrival;
    logic [15:0] service;
    logic [15:0] deadline;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // One result record.
  typedef struct packed {
    evt_e_t      ev;
    logic [15:0] job;
    logic [31:0] tm;
    logic [31:0] wait_ticks;
    logic [31:0] turn_ticks;
    logic        met;
    logic        last;
  } res_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return q;
  endfunction

endpackage

// File: rtl/fjq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fjq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fjq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS job queue core
// Queue state, time counter and event generation for one request per cycle.
// ----------------------------------------------------------------------------
module fjq_core
  import fjq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       proc,
  input  itm_t       itm,
  output res_t       r0,
  output res_t       r1,
  output logic [1:0] nres
);

  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [15:0]      rem_r, rem_nxt;
  ent_t             hd_r, hd_nxt;

  logic             wr_en;
  ent_t             wr_ent;
  logic [PTR_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             fwd_sel_r;
  ent_t             fwd_ent_r;
  ent_t             second;

  logic [31:0]      now_inc, turn, wait_v;

  // The RAM always looks ahead at the slot behind the head, so the next job
  // is ready the moment the head finishes. A write to that very slot is
  // forwarded around the RAM.
  fjq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail_r),
    .wdata (wr_ent),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign second  = fwd_sel_r ? fwd_ent_r : ent_t'(rd_data);
  assign rd_addr = next_slot(head_nxt);

  assign wr_ent.job_id   = itm.job_id;
  assign wr_ent.arrival  = now_r;
  assign wr_ent.service  = itm.service_ticks;
  assign wr_ent.deadline = itm.deadline_ticks;

  assign now_inc = now_r + 32'd1;
  assign turn    = now_inc - hd_r.arrival;
  assign wait_v  = turn - {16'h0, hd_r.service};

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    now_nxt  = now_r;
    rem_nxt  = rem_r;
    hd_nxt   = hd_r;
    wr_en    = 1'b0;
    r0       = '0;
    r1       = '0;
    nres     = 2'd0;
    if (proc) begin
      if (itm.kind == KIND_ARRIVE) begin
        r0.job = itm.job_id;
        r0.tm  = now_r;
        if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
          r0.ev   = EV_REJECTED;
          r0.last = 1'b1;
          nres    = 2'd1;
        end else begin
          wr_en    = 1'b1;
          tail_nxt = next_slot(tail_r);
          occ_nxt  = occ_r + OCC_W'(1);
          r0.ev    = EV_ENTERED;
          if (occ_r == '0) begin
            hd_nxt  = wr_ent;
            rem_nxt = itm.service_ticks;
            r1.ev   = EV_RUNNING;
            r1.job  = itm.job_id;
            r1.tm   = now_r;
            r1.last = 1'b1;
            nres    = 2'd2;
          end else begin
            r0.last = 1'b1;
            nres    = 2'd1;
          end
        end
      end else begin
        now_nxt = now_inc;
        if (occ_r != '0) begin
          if (rem_r > 16'd1) begin
            rem_nxt = rem_r - 16'd1;
          end else begin
            r0.ev         = EV_FINISHED;
            r0.job        = hd_r.job_id;
            r0.tm         = now_inc;
            r0.wait_ticks = wait_v;
            r0.turn_ticks = turn;
            r0.met        = (turn <= {16'h0, hd_r.deadline});
            head_nxt      = next_slot(head_r);
            occ_nxt       = occ_r - OCC_W'(1);
            rem_nxt       = 16'd0;
            if (occ_r > OCC_W'(1)) begin
              hd_nxt  = second;
              rem_nxt = second.service;
              r1.ev   = EV_RUNNING;
              r1.job  = second.job_id;
              r1.tm   = now_inc;
              r1.last = 1'b1;
              nres    = 2'd2;
            end else begin
              r0.last = 1'b1;
              nres    = 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
      now_r  <= '0;
      rem_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
      now_r  <= now_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hd_r      <= hd_nxt;
    fwd_sel_r <= wr_en && (tail_r == rd_addr);
    fwd_ent_r <= wr_ent;
  end

endmodule

// File: rtl/fjq_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS job queue result buffer
// Two-entry result register that takes up to two results per request.
// ----------------------------------------------------------------------------
module fjq_outbuf
  import fjq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       r0,
  input  res_t       r1,
  input  logic [1:0] nres,
  output logic       room,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       out_res
);

  res_t       slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = slot0_r;
  assign pop       = out_valid && !out_stall;
  // The buffer has room once everything in it is gone by the end of this cycle.
  assign room      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slot0_nxt = r0;
      slot1_nxt = r1;
      cnt_nxt   = nres;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// File: rtl/fcfs_job_queue_accounting_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS job queue accounting unit
// A request passes the input register and then the result buffer. One request
// per cycle while each yields at most one result and the output is not
// stalled; a two-result request holds the two-entry result buffer until its
// second result is taken. Reset is synchronous and active low, clears the
// pointers, occupancy, time and remaining count at once; no clearing pass.
// ----------------------------------------------------------------------------
module fcfs_job_queue_accounting_unit
  import fjq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_service_ticks,
  input  logic [15:0] in_deadline_ticks,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [15:0] out_event_job,
  output logic [31:0] out_event_time,
  output logic [31:0] out_wait_ticks,
  output logic [31:0] out_turnaround_ticks,
  output logic        out_deadline_met,
  output logic        out_last
);

  // A request first lands in the input register. It is processed once the
  // result buffer can take both possible results; processing updates the
  // queue state and loads the buffer at the same edge.

  logic       itm_valid_r, itm_valid_nxt;
  itm_t       itm_r;
  logic       in_take;
  logic       proc;
  logic       room;
  res_t       r0, r1, out_res;
  logic [1:0] nres;

  assign proc     = itm_valid_r && room;
  assign in_stall = itm_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    itm_valid_nxt = itm_valid_r;
    if (in_take) begin
      itm_valid_nxt = 1'b1;
    end else if (proc) begin
      itm_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_valid_r <= 1'b0;
    end else begin
      itm_valid_r <= itm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      itm_r.kind           <= in_kind;
      itm_r.job_id         <= in_job_id;
      itm_r.service_ticks  <= in_service_ticks;
      itm_r.deadline_ticks <= in_deadline_ticks;
    end
  end

  // Queue state, job look-ahead and event generation.
  fjq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (proc),
    .itm   (itm_r),
    .r0    (r0),
    .r1    (r1),
    .nres  (nres)
  );

  // Result register; a second result waits here while the first is taken.
  fjq_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc),
    .r0        (r0),
    .r1        (r1),
    .nres      (nres),
    .room      (room),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_event_res        = out_res.ev;
  assign out_event_job        = out_res.job;
  assign out_event_time       = out_res.tm;
  assign out_wait_ticks       = out_res.wait_ticks;
  assign out_turnaround_ticks = out_res.turn_ticks;
  assign out_deadline_met     = out_res.met;
  assign out_last             = out_res.last;

endmodule

// File: tb/fcfs_job_queue_accounting_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FCFS job queue accounting unit testbench
// Drives arrival and tick requests into the job queue, predicts every event it
// should report (entered, running, finished, rejected), and checks each result
// field by field in order. Both channels idle at random, with quiet stretches.
// ----------------------------------------------------------------------------
module fcfs_job_queue_accounting_unit_tb;
  import fjq_pkg::*;

  // The slowest correct run (long sender gaps, two results per request, each
  // held by a long receiver stall) stays well under this many cycles.
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [15:0] in_job_id;
  logic [15:0] in_service_ticks;
  logic [15:0] in_deadline_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_res;
  logic [15:0] out_event_job;
  logic [31:0] out_event_time;
  logic [31:0] out_wait_ticks;
  logic [31:0] out_turnaround_ticks;
  logic        out_deadline_met;
  logic        out_last;

  fcfs_job_queue_accounting_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_job_id            (in_job_id),
    .in_service_ticks     (in_service_ticks),
    .in_deadline_ticks    (in_deadline_ticks),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_res        (out_event_res),
    .out_event_job        (out_event_job),
    .out_event_time       (out_event_time),
    .out_wait_ticks       (out_wait_ticks),
    .out_turnaround_ticks (out_turnaround_ticks),
    .out_deadline_met     (out_deadline_met),
    .out_last             (out_last)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the job queue. It is updated once per accepted request and
  // appends the events that request must cause to pending_events.
  // --------------------------------------------------------------------------
  logic [15:0] shadow_id       [QUEUE_DEPTH];
  logic [31:0] shadow_arrival  [QUEUE_DEPTH];
  logic [15:0] shadow_service  [QUEUE_DEPTH];
  logic [15:0] shadow_deadline [QUEUE_DEPTH];
  logic [15:0] head_left;
  int          head_slot;
  int          tail_slot;
  int          job_count;
  logic [31:0] now_ticks;

  res_t pending_events[$];
  res_t want;

  int errors;
  int cycle_count;
  int requests_sent;
  int arrivals_sent;
  int results_checked;
  int finished_seen;
  int rejected_seen;
  int quiet_in;
  int quiet_out;

  function automatic res_t make_event(input evt_e_t ev, input logic [15:0] job,
                                      input logic [31:0] tm, input logic [31:0] wt,
                                      input logic [31:0] turn, input logic met);
    res_t r;
    r.ev         = ev;
    r.job        = job;
    r.tm         = tm;
    r.wait_ticks = wt;
    r.turn_ticks = turn;
    r.met        = met;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic int wrap_slot(input int s);
    return (s == QUEUE_DEPTH - 1) ? 0 : s + 1;
  endfunction

  task automatic predict_events(input logic kind, input logic [15:0] id,
                                input logic [15:0] svc, input logic [15:0] dl);
    res_t        evs[$];
    logic [31:0] turn;
    if (kind == KIND_ARRIVE) begin
      if (job_count >= QUEUE_DEPTH) begin
        // Full queue: the job is dropped and nothing else changes.
        evs.push_back(make_event(EV_REJECTED, id, now_ticks, '0, '0, 1'b0));
      end else begin
        shadow_id[tail_slot]       = id;
        shadow_arrival[tail_slot]  = now_ticks;
        shadow_service[tail_slot]  = svc;
        shadow_deadline[tail_slot] = dl;
        tail_slot = wrap_slot(tail_slot);
        job_count++;
        evs.push_back(make_event(EV_ENTERED, id, now_ticks, '0, '0, 1'b0));
        if (job_count == 1) begin
          // An arrival into an empty queue starts running at once.
          head_left = svc;
          evs.push_back(make_event(EV_RUNNING, id, now_ticks, '0, '0, 1'b0));
        end
      end
    end else begin
      now_ticks = now_ticks + 32'd1;
      if (job_count > 0) begin
        if (head_left > 16'd1) begin
          head_left = head_left - 16'd1;
        end else begin
          // A remaining count of one or zero finishes the head job on this tick.
          turn = now_ticks - shadow_arrival[head_slot];
          evs.push_back(make_event(EV_FINISHED, shadow_id[head_slot], now_ticks,
                                   turn - {16'd0, shadow_service[head_slot]}, turn,
                                   turn <= {16'd0, shadow_deadline[head_slot]}));
          head_slot = wrap_slot(head_slot);
          job_count--;
          head_left = '0;
          if (job_count > 0) begin
            head_left = shadow_service[head_slot];
            evs.push_back(make_event(EV_RUNNING, shadow_id[head_slot], now_ticks,
                                     '0, '0, 1'b0));
          end
        end
      end
    end
    if (evs.size() > 0) begin
      evs[evs.size() - 1].last = 1'b1;
    end
    foreach (evs[i]) begin
      pending_events.push_back(evs[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle lengths: mostly zero or short, a few long, and now and then a quiet
  // stretch of back-to-back traffic.
  // --------------------------------------------------------------------------
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Valid is left high after an accept so that a following
  // request with no gap keeps it high without a second assignment in the same
  // step; it is lowered only when a gap begins.
  // --------------------------------------------------------------------------
  task automatic issue_request(input logic kind, input logic [15:0] id,
                               input logic [15:0] svc, input logic [15:0] dl);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= kind;
    in_job_id         <= id;
    in_service_ticks  <= svc;
    in_deadline_ticks <= dl;
    do @(posedge clk); while (in_stall);
    // Accepted at this edge.
    predict_events(kind, id, svc, dl);
    requests_sent++;
    if (kind == KIND_ARRIVE) arrivals_sent++;
  endtask

  // A tick carries random junk in the job fields, which the block must ignore.
  task automatic issue_tick();
    issue_request(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic issue_arrival(input logic [15:0] id, input logic [15:0] svc,
                               input logic [15:0] dl);
    issue_request(KIND_ARRIVE, id, svc, dl);
  endtask

  task automatic drain_queue();
    while (job_count > 0) issue_tick();
  endtask

  function automatic logic [15:0] random_service();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)  return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 6));
    if (r < 97) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(41, 300));
  endfunction

  function automatic logic [15:0] random_deadline();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 20));
    if (r < 80) return 16'($urandom_range(0, 300));
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Ticks on an empty queue only advance time and report nothing.
  task automatic test_idle_ticks();
    repeat (3) issue_tick();
  endtask

  // Field extremes, a zero service time, deadlines met and missed, and a job
  // that waits behind others.
  task automatic test_directed_jobs();
    issue_arrival(16'h0000, 16'd1, 16'd0);
    issue_arrival(16'hFFFF, 16'd0, 16'hFFFF);
    issue_arrival(16'h5A5A, 16'd3, 16'd2);
    issue_arrival(16'hA5A5, 16'd2, 16'd7);
    repeat (4) issue_tick();
    issue_arrival(16'h1234, 16'd2, 16'd1);
    drain_queue();
    issue_arrival(16'h00FF, 16'd1, 16'd1);
    issue_tick();
    issue_tick();
  endtask

  // Fill all slots, push two extra arrivals that are rejected, free one slot,
  // refill it, push one more arrival that is rejected, and drain.
  task automatic test_queue_full();
    drain_queue();
    repeat (QUEUE_DEPTH) begin
      issue_arrival(16'($urandom), 16'($urandom_range(1, 2)), random_deadline());
    end
    issue_arrival(16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_arrival(16'h0000, 16'd1, 16'd0);
    while (job_count == QUEUE_DEPTH) issue_tick();
    issue_arrival(16'($urandom), 16'd1, random_deadline());
    issue_arrival(16'($urandom), 16'd1, random_deadline());
    drain_queue();
  endtask

  // Random traffic in phases of varying arrival rate, so that the queue runs
  // empty, sits partly filled, and overflows.
  task automatic test_random_traffic();
    int arrive_pct;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 4))
          0: arrive_pct = 15;
          1: arrive_pct = 35;
          2: arrive_pct = 50;
          3: arrive_pct = 70;
          default: arrive_pct = 90;
        endcase
      end
      if ($urandom_range(0, 99) < arrive_pct) begin
        issue_arrival(16'($urandom), random_service(), random_deadline());
      end else begin
        issue_tick();
      end
    end
  endtask

  // Long service times that set the upper bits; these jobs are not run out.
  task automatic test_long_service();
    drain_queue();
    issue_arrival(16'($urandom), 16'hFFFF, 16'($urandom));
    issue_arrival(16'($urandom), 16'h8000, 16'($urandom));
    issue_arrival(16'($urandom), 16'h7FFF, 16'($urandom));
    repeat (10) issue_tick();
  endtask

  // --------------------------------------------------------------------------
  // Result checker.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
               exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: result with no expected event, expected none, actual ev %0d job %0h",
                 $time, out_event_res, out_event_job);
        errors++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 32'(want.ev), 32'(out_event_res));
        check_field("event_job", 32'(want.job), 32'(out_event_job));
        check_field("event_time", want.tm, out_event_time);
        check_field("wait_ticks", want.wait_ticks, out_wait_ticks);
        check_field("turnaround_ticks", want.turn_ticks, out_turnaround_ticks);
        check_field("deadline_met", 32'(want.met), 32'(out_deadline_met));
        check_field("last", 32'(want.last), 32'(out_last));
        results_checked++;
        if (want.ev == EV_FINISHED) finished_seen++;
        if (want.ev == EV_REJECTED) rejected_seen++;
      end
    end
  end

  // Receiver side: random stalls with open stretches in between.
  initial begin : out_stall_driver
    int n;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      n = pick_gap(quiet_out);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    errors          = 0;
    cycle_count     = 0;
    requests_sent   = 0;
    arrivals_sent   = 0;
    results_checked = 0;
    finished_seen   = 0;
    rejected_seen   = 0;
    quiet_in        = 0;
    quiet_out       = 0;
    head_left       = '0;
    head_slot       = 0;
    tail_slot       = 0;
    job_count       = 0;
    now_ticks       = '0;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= KIND_TICK;
    in_job_id         <= '0;
    in_service_ticks  <= '0;
    in_deadline_ticks <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_directed_jobs();
    test_queue_full();
    test_random_traffic();
    test_long_service();

    in_valid <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d arrivals); checked %0d events, %0d finished, %0d rejected.",
             requests_sent, arrivals_sent, results_checked, finished_seen, rejected_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
